### hw/rtl/smpq_pkg.sv
// Package: shared constants, codes and control structs for the sorted min priority queue.
`default_nettype none
package smpq_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int KEY_W   = 32;
   localparam int LIMIT_W = 7;
   localparam int ENTRY_W = 7;
   localparam int LIMIT_RESET = (64 > DEPTH) ? DEPTH : 64;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic ins_empty;
      logic ins_first;
      logic shift;
      logic place;
      logic pop;
      logic read_head;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_insert;
      logic full;
      logic count_zero;
      logic greater;
      logic pos_one;
      logic out_free;
   } dp_stat_type;

   // circular slot address: base plus offset, wrapped at DEPTH
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return ADDR_W'(sum);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/smpq_if.sv
// Interfaces: request, response and control register channels of the priority queue.
`default_nettype none
interface smpq_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] value;
   modport source (output valid, op, value, input ready);
   modport sink   (input valid, op, value, output ready);
endinterface

interface smpq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] head_value;
   logic               head_valid;
   logic [6:0]         entry_count;
   logic               is_full;
   logic               is_empty;
   modport source (output valid, status, head_value, head_valid, entry_count, is_full,
                   is_empty, input ready);
   modport sink   (input valid, status, head_value, head_valid, entry_count, is_full,
                   is_empty, output ready);
endinterface

interface smpq_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/smpq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module smpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### hw/rtl/smpq_ctrl.sv
// Controller: sequences accept, insert walk, remove and head readback.
`default_nettype none
module smpq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire smpq_pkg::dp_stat_type stat,
   output      smpq_pkg::dp_cmd_type  cmd
);
   import smpq_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECIDE = 6'b000010,
      S_CMP    = 6'b000100,
      S_PLACE  = 6'b001000,
      S_READH  = 6'b010000,
      S_HEADW  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_READH;
            if (stat.is_insert) begin
               if (!stat.full) begin
                  if (stat.count_zero) begin
                     cmd.ins_empty = 1'b1;
                  end else begin
                     cmd.ins_first = 1'b1;
                     state_in      = S_CMP;
                  end
               end
            end else if (!stat.count_zero) begin
               cmd.pop = 1'b1;
            end
         end
         S_CMP: begin
            if (stat.greater) begin
               cmd.shift = 1'b1;
               if (stat.pos_one) begin
                  state_in = S_PLACE;
               end
            end else begin
               cmd.place = 1'b1;
               state_in  = S_READH;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_READH;
         end
         S_READH: begin
            cmd.read_head = 1'b1;
            state_in      = S_HEADW;
         end
         S_HEADW: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/smpq_dp.sv
// Datapath: count, head pointer, insert walk position, limit and result register.
`default_nettype none
module smpq_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire smpq_pkg::dp_cmd_type   cmd,
   output      smpq_pkg::dp_stat_type  stat,
   input  wire logic                  req_op,
   input  wire logic signed [31:0]    req_value,
   input  wire logic                  csr_we,
   input  wire logic [6:0]            csr_data,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_valid,
   output      logic [1:0]            rsp_status,
   output      logic signed [31:0]    rsp_head_value,
   output      logic                  rsp_head_valid,
   output      logic [6:0]            rsp_entry_count,
   output      logic                  rsp_is_full,
   output      logic                  rsp_is_empty
);
   import smpq_pkg::*;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        lim_ff, lim_in;
   logic signed [KEY_W-1:0] key_ff;
   logic                    op_ff;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff;
   logic [1:0]              o_status_ff;
   logic signed [KEY_W-1:0] o_head_ff;
   logic                    o_hvalid_ff;
   logic [ENTRY_W-1:0]      o_count_ff;
   logic                    o_full_ff;
   logic                    o_empty_ff;

   logic                    wr_en, rd_en;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [KEY_W-1:0]        wr_data, rd_data;
   logic signed [KEY_W-1:0] rd_key;
   logic                    full;
   logic                    out_free;

   smpq_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key   = rd_data;
   assign full     = (count_ff >= lim_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign stat.is_insert  = (op_ff == OP_INSERT);
   assign stat.full       = full;
   assign stat.count_zero = (count_ff == '0);
   assign stat.greater    = (rd_key > key_ff);
   assign stat.pos_one    = (pos_ff == CNT_W'(1));
   assign stat.out_free   = out_free;

   // store access
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = key_ff;
      rd_en   = 1'b0;
      rd_addr = head_ff;
      if (cmd.ins_empty) begin
         wr_en = 1'b1;
      end
      if (cmd.ins_first) begin
         rd_en   = 1'b1;
         rd_addr = wrap_add(head_ff, count_ff - CNT_W'(1));
      end
      if (cmd.shift) begin
         wr_en   = 1'b1;
         wr_addr = wrap_add(head_ff, pos_ff);
         wr_data = rd_data;
         rd_en   = 1'b1;
         rd_addr = wrap_add(head_ff, (pos_ff >= CNT_W'(2)) ? pos_ff - CNT_W'(2) : '0);
      end
      if (cmd.place) begin
         wr_en   = 1'b1;
         wr_addr = wrap_add(head_ff, pos_ff);
      end
      if (cmd.read_head) begin
         rd_en = 1'b1;
      end
   end

   // control state
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      pos_in    = pos_ff;
      lim_in    = lim_ff;
      status_in = status_ff;
      if (csr_we) begin
         if (csr_data == '0) begin
            lim_in = CNT_W'(1);
         end else if (32'(csr_data) > DEPTH) begin
            lim_in = CNT_W'(DEPTH);
         end else begin
            lim_in = CNT_W'(csr_data);
         end
      end
      if (cmd.decide) begin
         if (op_ff == OP_INSERT) begin
            status_in = full ? ST_FULL : ST_DONE;
         end else begin
            status_in = (count_ff == '0) ? ST_EMPTY : ST_DONE;
         end
      end
      if (cmd.ins_empty || cmd.place) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.ins_first) begin
         pos_in = count_ff;
      end
      if (cmd.shift) begin
         pos_in = pos_ff - CNT_W'(1);
      end
      if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         head_in  = wrap_add(head_ff, CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         pos_ff       <= '0;
         lim_ff       <= CNT_W'(LIMIT_RESET);
         status_ff    <= ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         head_ff   <= head_in;
         pos_ff    <= pos_in;
         lim_ff    <= lim_in;
         status_ff <= status_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         key_ff <= req_value;
      end
      if (cmd.emit) begin
         o_status_ff <= status_ff;
         o_head_ff   <= (count_ff == '0) ? '0 : rd_key;
         o_hvalid_ff <= (count_ff != '0);
         o_count_ff  <= ENTRY_W'(count_ff);
         o_full_ff   <= full;
         o_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_head_value  = o_head_ff;
   assign rsp_head_valid  = o_hvalid_ff;
   assign rsp_entry_count = o_count_ff;
   assign rsp_is_full     = o_full_ff;
   assign rsp_is_empty    = o_empty_ff;
endmodule
`default_nettype wire

### hw/rtl/sorted_min_priority_queue.sv
// Top level: sorted-array min priority queue held as a circular buffer in one RAM.
// Remove, refused item or insert into an empty queue: decide, head read, then the response
// waits for a free output register. Insert into a non-empty queue first walks the stored
// keys greater than the new key; the walk moves one entry per cycle through the
// RAM's single write port. One item in flight; a new item is taken while the previous
// response waits, and a held response stalls the next one. Reset: empty queue, limit 64.
`default_nettype none
module sorted_min_priority_queue (
   input wire logic clock,
   input wire logic reset,
   smpq_req_if.sink   req_ch,
   smpq_rsp_if.source rsp_ch,
   smpq_csr_if.sink   csr_ch
);
   import smpq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ch.ready = 1'b1;

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smpq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_ch.op),
      .req_value       (req_ch.value),
      .csr_we          (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_head_value  (rsp_ch.head_value),
      .rsp_head_valid  (rsp_ch.head_valid),
      .rsp_entry_count (rsp_ch.entry_count),
      .rsp_is_full     (rsp_ch.is_full),
      .rsp_is_empty    (rsp_ch.is_empty)
   );
endmodule
`default_nettype wire

### sim/sorted_min_priority_queue_tb.sv
// Testbench: drives the sorted min priority queue and checks every response against a shadow queue.
`timescale 1ns / 100ps
module sorted_min_priority_queue_tb;
   import smpq_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] head_value;
      logic               head_valid;
      logic [6:0]         entry_count;
      logic               is_full;
      logic               is_empty;
   } queue_result_type;

   logic clock;
   logic reset;

   smpq_req_if req_if ();
   smpq_rsp_if rsp_if ();
   smpq_csr_if csr_if ();

   sorted_min_priority_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // shadow copy of the queue
   logic signed [31:0] shadow_keys [DEPTH];
   int unsigned        shadow_count;
   logic [6:0]         shadow_limit;

   queue_result_type pending_results [$];
   int               fail_count;
   int               cycle_count;
   int               send_idle_pct;
   int               stall_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned active_limit();
      if (shadow_limit == 7'd0) return 1;
      if (shadow_limit > DEPTH) return DEPTH;
      return shadow_limit;
   endfunction

   function automatic queue_result_type queue_step(input logic op,
                                                   input logic signed [31:0] key);
      queue_result_type r;
      int unsigned      lim;
      int unsigned      pos;
      lim = active_limit();
      r.status = ST_DONE;
      if (op == OP_INSERT) begin
         if (shadow_count >= lim) begin
            r.status = ST_FULL;
         end else begin
            pos = shadow_count;
            while (pos > 0 && shadow_keys[pos-1] > key) begin
               shadow_keys[pos] = shadow_keys[pos-1];
               pos--;
            end
            shadow_keys[pos] = key;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         for (int i = 1; i < shadow_count; i++) shadow_keys[i-1] = shadow_keys[i];
         shadow_count--;
      end
      r.head_value  = (shadow_count > 0) ? shadow_keys[0] : 32'sd0;
      r.head_valid  = (shadow_count > 0);
      r.entry_count = 7'(shadow_count);
      r.is_full     = (shadow_count >= lim);
      r.is_empty    = (shadow_count == 0);
      return r;
   endfunction

   function automatic void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no item outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_if.status);
            check_field("head_value", want.head_value, rsp_if.head_value);
            check_field("head_valid", want.head_valid, rsp_if.head_valid);
            check_field("entry_count", want.entry_count, rsp_if.entry_count);
            check_field("is_full", want.is_full, rsp_if.is_full);
            check_field("is_empty", want.is_empty, rsp_if.is_empty);
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic op, input logic signed [31:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op    <= op;
      req_if.value <= key;
      do @(posedge clock); while (!req_if.ready);
      pending_results.push_back(queue_step(op, key));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [6:0] limit);
      req_if.valid <= 1'b0;
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.data  <= limit;
      do @(posedge clock); while (!csr_if.ready);
      shadow_limit = limit;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_key();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) return 32'(int'($urandom_range(16)) - 8);
      if (pick < 50) begin
         case ($urandom_range(3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic test_empty_and_extreme_keys();
      send_item(OP_REMOVE, 32'sd0);
      send_item(OP_INSERT, 32'sh7fffffff);
      send_item(OP_INSERT, 32'sh80000000);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_REMOVE, 32'sh7fffffff);
      send_item(OP_REMOVE, -32'sd1);
      send_item(OP_INSERT, 32'sh55555555);
      send_item(OP_INSERT, 32'shaaaaaaaa);
   endtask

   // limit of zero acts as one, and is set while entries are held
   task automatic test_limit_below_count();
      write_limit(7'd0);
      send_item(OP_INSERT, 32'sd5);
      repeat (6) send_item(OP_REMOVE, 32'sd0);
      send_item(OP_INSERT, 32'sd9);
      send_item(OP_INSERT, 32'sd3);
      write_limit(7'd1);
      send_item(OP_INSERT, -32'sd3);
      send_item(OP_REMOVE, 32'sd0);
   endtask

   task automatic test_random_mix(input int idle_pct, input int stall, input logic [6:0] limit,
                                  input int items);
      int sent;
      int burst;
      int insert_pct;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      write_limit(limit);
      sent = 0;
      while (sent < items) begin
         if (sent > 0 && $urandom_range(3) == 0) write_limit(7'($urandom_range(127)));
         burst = $urandom_range(40, 80);
         if (burst > items - sent) burst = items - sent;
         case ($urandom_range(2))
            0: insert_pct = 80;
            1: insert_pct = 50;
            default: insert_pct = 25;
         endcase
         repeat (burst) begin
            send_item(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE, random_key());
         end
         sent += burst;
      end
   endtask

   initial begin
      reset         = 1'b1;
      fail_count    = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      shadow_count  = 0;
      shadow_limit  = 7'd64;
      req_if.valid  = 1'b0;
      req_if.op     = OP_INSERT;
      req_if.value  = '0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_extreme_keys();
      test_limit_below_count();
      test_random_mix(0, 0, 7'd127, 390);
      test_random_mix(46, 0, 7'd64, 390);
      test_random_mix(0, 46, 7'($urandom_range(2, 20)), 390);
      test_random_mix(26, 26, 7'($urandom_range(1, 126)), 390);

      req_if.valid <= 1'b0;
      wait_idle();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_if.sv
hw/rtl/smpq_ram.sv
hw/rtl/smpq_ctrl.sv
hw/rtl/smpq_dp.sv
hw/rtl/sorted_min_priority_queue.sv
sim/sorted_min_priority_queue_tb.sv
